FILE: hw/rtl/cpp_pkg.sv
`default_nettype none

package cpp_pkg;

    // pipeline depth: stage 0 takes the input, stage NSTG-1 is the output register
    localparam int NSTG     = 51;
    // quotient bits of the depth divide, one per stage
    localparam int DIV_BITS = 31;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [62:0] ROT0_RST = 63'd524288;
    localparam logic [62:0] ROT1_RST = 63'd1 << 40;
    localparam logic [62:0] ROT2_RST = 63'd1 << 61;
    localparam logic [63:0] INTR_RST = 64'd256;

    localparam logic [61:0] LIM62    = {62{1'b1}};
    localparam logic [30:0] NORM_MAX = {31{1'b1}};

    typedef enum logic [2:0] {
        REG_ROT0  = 3'd0,
        REG_ROT1  = 3'd1,
        REG_ROT2  = 3'd2,
        REG_TX    = 3'd3,
        REG_TY    = 3'd4,
        REG_TZ    = 3'd5,
        REG_DIST  = 3'd6,
        REG_INTR  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic vld;
        logic zero;
        logic sat;
    } t_ctl;

    typedef struct packed {
        logic [30:0] xm;
        logic        xn;
        logic [30:0] ym;
        logic        yn;
    } t_xy;

endpackage

`default_nettype wire

FILE: hw/rtl/camera_point_projection.sv
`default_nettype none

// channel   direction  handshake            payload
// point     in         i_valid / o_stall    i_point_x, i_point_y, i_point_z
// pixel     out        o_valid / i_stall    o_pixel_u, o_pixel_v, o_status
// config    in         APB psel / penable   paddr, pwdata, prdata (64 bit, reg i at 8*i)
//
// One point per clock while the output is not stalled; 51 register stages, their depth
// set by the 31-stage restoring divide of x and y by depth followed by the split
// multiplies of the distortion chain.
// A stalled output freezes the whole pipeline in place; o_stall is high only then.
// Reset clears all stage valid bits and restores the configuration registers.

module camera_point_projection (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_stall,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    output      logic               o_valid,
    input  wire logic               i_stall,
    output      logic signed [31:0] o_pixel_u,
    output      logic signed [31:0] o_pixel_v,
    output      logic [1:0]         o_status,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output      logic [63:0]        prdata,
    output      logic               pready
);

    localparam int NS = cpp_pkg::NSTG;
    localparam int DB = cpp_pkg::DIV_BITS;

    // configuration
    logic [62:0] r_rot0, r_rot1, r_rot2;
    logic [31:0] r_tx, r_ty, r_tz;
    logic [63:0] r_dist, r_intr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot0 <= cpp_pkg::ROT0_RST;
            r_rot1 <= cpp_pkg::ROT1_RST;
            r_rot2 <= cpp_pkg::ROT2_RST;
            r_tx   <= '0;
            r_ty   <= '0;
            r_tz   <= '0;
            r_dist <= '0;
            r_intr <= cpp_pkg::INTR_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (cpp_pkg::t_reg_idx'(paddr[5:3]))
                cpp_pkg::REG_ROT0: r_rot0 <= pwdata[62:0];
                cpp_pkg::REG_ROT1: r_rot1 <= pwdata[62:0];
                cpp_pkg::REG_ROT2: r_rot2 <= pwdata[62:0];
                cpp_pkg::REG_TX:   r_tx   <= pwdata[31:0];
                cpp_pkg::REG_TY:   r_ty   <= pwdata[31:0];
                cpp_pkg::REG_TZ:   r_tz   <= pwdata[31:0];
                cpp_pkg::REG_DIST: r_dist <= pwdata;
                cpp_pkg::REG_INTR: r_intr <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cpp_pkg::t_reg_idx'(paddr[5:3]))
            cpp_pkg::REG_ROT0: prdata = {1'b0, r_rot0};
            cpp_pkg::REG_ROT1: prdata = {1'b0, r_rot1};
            cpp_pkg::REG_ROT2: prdata = {1'b0, r_rot2};
            cpp_pkg::REG_TX:   prdata = {32'b0, r_tx};
            cpp_pkg::REG_TY:   prdata = {32'b0, r_ty};
            cpp_pkg::REG_TZ:   prdata = {32'b0, r_tz};
            cpp_pkg::REG_DIST: prdata = r_dist;
            cpp_pkg::REG_INTR: prdata = r_intr;
            default:           prdata = '0;
        endcase
    end

    // unpacked configuration fields
    logic signed [20:0] rc [0:8];
    logic signed [31:0] tr [0:2];
    logic signed [31:0] pt [0:2];
    logic signed [31:0] k1, k2;
    logic [31:0]        k1m, k2m;
    logic               k1_neg, k2_neg;
    logic [23:0]        focal;
    logic [19:0]        cx, cy;

    assign rc[0] = r_rot0[20:0];
    assign rc[1] = r_rot0[41:21];
    assign rc[2] = r_rot0[62:42];
    assign rc[3] = r_rot1[20:0];
    assign rc[4] = r_rot1[41:21];
    assign rc[5] = r_rot1[62:42];
    assign rc[6] = r_rot2[20:0];
    assign rc[7] = r_rot2[41:21];
    assign rc[8] = r_rot2[62:42];
    assign tr[0] = r_tx;
    assign tr[1] = r_ty;
    assign tr[2] = r_tz;
    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;
    assign k1     = r_dist[31:0];
    assign k2     = r_dist[63:32];
    assign k1_neg = k1[31];
    assign k2_neg = k2[31];
    assign k1m    = k1_neg ? 32'(-k1) : 32'(k1);
    assign k2m    = k2_neg ? 32'(-k2) : 32'(k2);
    assign focal  = r_intr[23:0];
    assign cx     = r_intr[43:24];
    assign cy     = r_intr[63:44];

    // pipeline control
    cpp_pkg::t_ctl r_ctl [0:NS-1];
    logic          adv;
    logic [NS-1:0] sat_add;

    assign adv     = !r_ctl[NS-1].vld || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_ctl[NS-1].vld;

    // payload registers
    logic signed [52:0] r_prod [0:8];
    logic signed [54:0] r_cc   [0:2];
    logic [54:0]        r_ca   [0:2];
    logic               r_cs   [0:2];

    logic [54:0] r_dx_rem [0:DB];
    logic [54:0] r_dy_rem [0:DB];
    logic [30:0] r_dx_nb  [0:DB];
    logic [30:0] r_dy_nb  [0:DB];
    logic [30:0] r_dx_q   [0:DB];
    logic [30:0] r_dy_q   [0:DB];
    logic [54:0] r_dd     [0:DB];
    logic        r_dx_sat [0:DB];
    logic        r_dy_sat [0:DB];
    logic        r_dx_n   [0:DB];
    logic        r_dy_n   [0:DB];

    cpp_pkg::t_xy r_xy [0:9];

    logic [61:0]        r_sqx, r_sqy;
    logic [38:0]        r_r2;
    logic [37:0]        r_hh;
    logic [38:0]        r_hl;
    logic [39:0]        r_ll;
    logic [51:0]        r_k1lo;
    logic [50:0]        r_k1hi;
    logic [53:0]        r_r4;
    logic [46:0]        r_t1m;
    logic [58:0]        r_k2lo, r_k2hi;
    logic signed [47:0] r_t1s_a, r_t1s_b, r_t1s_c;
    logic [61:0]        r_t2m;
    logic signed [62:0] r_t2s;
    logic signed [63:0] r_fac;
    logic [61:0]        r_fm;
    logic               r_fn;
    logic [61:0]        r_su_pl, r_su_ph, r_sv_pl, r_sv_ph;
    logic               r_su_n, r_sv_n;
    logic [61:0]        r_su, r_sv;
    logic               r_su_n2, r_sv_n2;
    logic [54:0]        r_pu_pl, r_pu_ph, r_pv_pl, r_pv_ph;
    logic               r_pu_n, r_pv_n;
    logic [61:0]        r_um, r_vm;
    logic               r_um_n, r_vm_n;
    logic signed [63:0] r_ut, r_vt;
    logic signed [31:0] r_pix_u, r_pix_v;
    logic [1:0]         r_status;

    // stage combinational terms
    logic        sat_nx, sat_ny;
    logic [92:0] su_prod, sv_prod;
    logic        su_sat, sv_sat;
    logic [85:0] pu_prod, pv_prod;
    logic        pu_sat, pv_sat;
    logic signed [63:0] n_su, n_sv;
    logic        clamp_u, clamp_v;
    logic signed [31:0] n_pix_u, n_pix_v;
    logic [1:0]  n_status;

    assign sat_nx = {7'b0, r_ca[0]} >= {r_ca[2], 7'b0};
    assign sat_ny = {7'b0, r_ca[1]} >= {r_ca[2], 7'b0};

    assign su_prod = (93'(r_su_ph) << 31) + 93'(r_su_pl);
    assign sv_prod = (93'(r_sv_ph) << 31) + 93'(r_sv_pl);
    assign su_sat  = |su_prod[92:86];
    assign sv_sat  = |sv_prod[92:86];

    assign pu_prod = (86'(r_pu_ph) << 31) + 86'(r_pu_pl);
    assign pv_prod = (86'(r_pv_ph) << 31) + 86'(r_pv_pl);
    assign pu_sat  = |pu_prod[85:78];
    assign pv_sat  = |pv_prod[85:78];

    assign n_su = r_ut + $signed({36'b0, cx, 8'b0});
    assign n_sv = r_vt + $signed({36'b0, cy, 8'b0});

    always_comb begin
        clamp_u = 1'b1;
        clamp_v = 1'b1;
        if (n_su > 64'sd2147483647)       n_pix_u = 32'sh7FFF_FFFF;
        else if (n_su < -64'sd2147483648) n_pix_u = 32'sh8000_0000;
        else begin
            n_pix_u = n_su[31:0];
            clamp_u = 1'b0;
        end
        if (n_sv > 64'sd2147483647)       n_pix_v = 32'sh7FFF_FFFF;
        else if (n_sv < -64'sd2147483648) n_pix_v = 32'sh8000_0000;
        else begin
            n_pix_v = n_sv[31:0];
            clamp_v = 1'b0;
        end
        if (r_ctl[NS-2].zero) begin
            n_pix_u  = '0;
            n_pix_v  = '0;
            n_status = cpp_pkg::ST_ZERO;
        end else if (r_ctl[NS-2].sat || clamp_u || clamp_v) begin
            n_status = cpp_pkg::ST_SAT;
        end else begin
            n_status = cpp_pkg::ST_OK;
        end
    end

    always_comb begin
        sat_add     = '0;
        sat_add[3]  = sat_nx || sat_ny;
        sat_add[46] = su_sat || sv_sat;
        sat_add[48] = pu_sat || pv_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_ctl[k] <= '0;
        end else if (adv) begin
            r_ctl[0] <= '{vld: i_valid, zero: 1'b0, sat: 1'b0};
            for (int k = 1; k < NS; k++) begin
                r_ctl[k].vld  <= r_ctl[k-1].vld;
                r_ctl[k].zero <= (k == 3) ? (r_ca[2] == '0) : r_ctl[k-1].zero;
                r_ctl[k].sat  <= r_ctl[k-1].sat || sat_add[k];
            end
        end
    end

    // camera transform, magnitudes, divider setup
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[3*i+j] <= 53'(rc[3*i+j]) * 53'(pt[j]);
                end
                r_cc[i] <= 55'(r_prod[3*i]) + 55'(r_prod[3*i+1]) + 55'(r_prod[3*i+2])
                         + (55'(tr[i]) <<< 19);
                r_ca[i] <= r_cc[i][54] ? 55'(-r_cc[i]) : 55'(r_cc[i]);
                r_cs[i] <= r_cc[i][54];
            end
            r_dx_rem[0] <= r_ca[0] >> 7;
            r_dy_rem[0] <= r_ca[1] >> 7;
            r_dx_nb[0]  <= {r_ca[0][6:0], 24'b0};
            r_dy_nb[0]  <= {r_ca[1][6:0], 24'b0};
            r_dx_q[0]   <= '0;
            r_dy_q[0]   <= '0;
            r_dd[0]     <= r_ca[2];
            r_dx_sat[0] <= sat_nx;
            r_dy_sat[0] <= sat_ny;
            r_dx_n[0]   <= r_cs[0] ^ r_cs[2];
            r_dy_n[0]   <= r_cs[1] ^ r_cs[2];
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 1; k <= DB; k++) begin : g_div
        logic [55:0] tx, ty;
        logic        gx, gy;

        assign tx = {r_dx_rem[k-1], r_dx_nb[k-1][30]};
        assign ty = {r_dy_rem[k-1], r_dy_nb[k-1][30]};
        assign gx = tx >= {1'b0, r_dd[k-1]};
        assign gy = ty >= {1'b0, r_dd[k-1]};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dx_rem[k] <= gx ? 55'(tx - {1'b0, r_dd[k-1]}) : tx[54:0];
                r_dy_rem[k] <= gy ? 55'(ty - {1'b0, r_dd[k-1]}) : ty[54:0];
                r_dx_nb[k]  <= {r_dx_nb[k-1][29:0], 1'b0};
                r_dy_nb[k]  <= {r_dy_nb[k-1][29:0], 1'b0};
                r_dx_q[k]   <= {r_dx_q[k-1][29:0], gx};
                r_dy_q[k]   <= {r_dy_q[k-1][29:0], gy};
                r_dd[k]     <= r_dd[k-1];
                r_dx_sat[k] <= r_dx_sat[k-1];
                r_dy_sat[k] <= r_dy_sat[k-1];
                r_dx_n[k]   <= r_dx_n[k-1];
                r_dy_n[k]   <= r_dy_n[k-1];
            end
        end
    end

    // distortion and intrinsics
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xy[0].xm <= r_dx_sat[DB] ? cpp_pkg::NORM_MAX : r_dx_q[DB];
            r_xy[0].xn <= r_dx_n[DB];
            r_xy[0].ym <= r_dy_sat[DB] ? cpp_pkg::NORM_MAX : r_dy_q[DB];
            r_xy[0].yn <= r_dy_n[DB];
            for (int j = 1; j < 10; j++) r_xy[j] <= r_xy[j-1];

            r_sqx <= 62'(r_xy[0].xm) * 62'(r_xy[0].xm);
            r_sqy <= 62'(r_xy[0].ym) * 62'(r_xy[0].ym);

            r_r2 <= 39'(r_sqx[61:24]) + 39'(r_sqy[61:24]);

            r_hh   <= 38'(r_r2[38:20]) * 38'(r_r2[38:20]);
            r_hl   <= 39'(r_r2[38:20]) * 39'(r_r2[19:0]);
            r_ll   <= 40'(r_r2[19:0]) * 40'(r_r2[19:0]);
            r_k1lo <= 52'(k1m) * 52'(r_r2[19:0]);
            r_k1hi <= 51'(k1m) * 51'(r_r2[38:20]);

            r_r4  <= 54'(((78'(r_hh) << 40) + (78'(r_hl) << 21) + 78'(r_ll)) >> 24);
            r_t1m <= 47'(((71'(r_k1hi) << 20) + 71'(r_k1lo)) >> 24);

            r_k2lo  <= 59'(k2m) * 59'(r_r4[26:0]);
            r_k2hi  <= 59'(k2m) * 59'(r_r4[53:27]);
            r_t1s_a <= k1_neg ? -$signed({1'b0, r_t1m}) : $signed({1'b0, r_t1m});

            r_t2m   <= 62'(((86'(r_k2hi) << 27) + 86'(r_k2lo)) >> 24);
            r_t1s_b <= r_t1s_a;

            r_t2s   <= k2_neg ? -$signed({1'b0, r_t2m}) : $signed({1'b0, r_t2m});
            r_t1s_c <= r_t1s_b;

            r_fac <= 64'sd16777216 + 64'(r_t1s_c) + 64'(r_t2s);

            r_fm <= r_fac[63] ? 62'(-r_fac) : 62'(r_fac);
            r_fn <= r_fac[63];

            r_su_pl <= 62'(r_fm[30:0]) * 62'(r_xy[9].xm);
            r_su_ph <= 62'(r_fm[61:31]) * 62'(r_xy[9].xm);
            r_sv_pl <= 62'(r_fm[30:0]) * 62'(r_xy[9].ym);
            r_sv_ph <= 62'(r_fm[61:31]) * 62'(r_xy[9].ym);
            r_su_n  <= r_fn ^ r_xy[9].xn;
            r_sv_n  <= r_fn ^ r_xy[9].yn;

            r_su    <= su_sat ? cpp_pkg::LIM62 : su_prod[85:24];
            r_sv    <= sv_sat ? cpp_pkg::LIM62 : sv_prod[85:24];
            r_su_n2 <= r_su_n;
            r_sv_n2 <= r_sv_n;

            r_pu_pl <= 55'(focal) * 55'(r_su[30:0]);
            r_pu_ph <= 55'(focal) * 55'(r_su[61:31]);
            r_pv_pl <= 55'(focal) * 55'(r_sv[30:0]);
            r_pv_ph <= 55'(focal) * 55'(r_sv[61:31]);
            r_pu_n  <= r_su_n2;
            r_pv_n  <= r_sv_n2;

            r_um   <= pu_sat ? cpp_pkg::LIM62 : pu_prod[77:16];
            r_vm   <= pv_sat ? cpp_pkg::LIM62 : pv_prod[77:16];
            r_um_n <= r_pu_n;
            r_vm_n <= r_pv_n;

            r_ut <= r_um_n ? -$signed({2'b0, r_um}) : $signed({2'b0, r_um});
            r_vt <= r_vm_n ? -$signed({2'b0, r_vm}) : $signed({2'b0, r_vm});

            r_pix_u  <= n_pix_u;
            r_pix_v  <= n_pix_v;
            r_status <= n_status;
        end
    end

    assign o_pixel_u = r_pix_u;
    assign o_pixel_v = r_pix_v;
    assign o_status  = r_status;

`ifndef NO_ASSERTIONS
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cpp_pkg::ST_ZERO) |-> (o_pixel_u == 0 && o_pixel_v == 0))
        else $error("zero-depth result with nonzero pixel");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic [1:0]         st;
    } t_pixel;

    class projection_board;
        logic [62:0] rot [3];
        logic [31:0] trans [3];
        logic [63:0] dcoef;
        logic [63:0] intr;
        t_pixel      pending_q [$];
        int          errors;
        int          checked;
        int          n_zero;
        int          n_sat;

        function new();
            rot[0]   = cpp_pkg::ROT0_RST;
            rot[1]   = cpp_pkg::ROT1_RST;
            rot[2]   = cpp_pkg::ROT2_RST;
            trans[0] = '0;
            trans[1] = '0;
            trans[2] = '0;
            dcoef    = '0;
            intr     = cpp_pkg::INTR_RST;
            errors   = 0;
            checked  = 0;
            n_zero   = 0;
            n_sat    = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(cpp_pkg::t_reg_idx idx, logic [63:0] val);
            case (idx)
                cpp_pkg::REG_ROT0: rot[0]   = val[62:0];
                cpp_pkg::REG_ROT1: rot[1]   = val[62:0];
                cpp_pkg::REG_ROT2: rot[2]   = val[62:0];
                cpp_pkg::REG_TX:   trans[0] = val[31:0];
                cpp_pkg::REG_TY:   trans[1] = val[31:0];
                cpp_pkg::REG_TZ:   trans[2] = val[31:0];
                cpp_pkg::REG_DIST: dcoef    = val;
                cpp_pkg::REG_INTR: intr     = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] magn(longint a);
            logic [63:0] ua;
            ua = a;
            if (a < 0) ua = ~ua + 64'd1;
            return ua;
        endfunction

        // trunc(a*b / 2^sh) with magnitude clamp at 2^62-1
        function longint mul_shift(longint a, longint b, int sh, inout bit sat);
            logic [127:0] prod;
            logic [127:0] r;
            logic [63:0]  rm;
            prod = {64'd0, magn(a)} * {64'd0, magn(b)};
            r    = prod >> sh;
            if (r > {66'd0, cpp_pkg::LIM62}) begin
                r   = {66'd0, cpp_pkg::LIM62};
                sat = 1'b1;
            end
            rm = r[63:0];
            return ((a < 0) != (b < 0)) ? -longint'(rm) : longint'(rm);
        endfunction

        function longint cam_coord(int r, longint px, longint py, longint pz);
            longint c0, c1, c2, t;
            c0 = {{43{rot[r][20]}}, rot[r][20:0]};
            c1 = {{43{rot[r][41]}}, rot[r][41:21]};
            c2 = {{43{rot[r][62]}}, rot[r][62:42]};
            t  = {{32{trans[r][31]}}, trans[r]};
            return c0 * px + c1 * py + c2 * pz + t * 524288;
        endfunction

        // trunc(n * 2^24 / d), clamped to Q7.24
        function longint norm_div(longint n, longint d, inout bit sat);
            logic [63:0]  un, ud, q;
            logic [127:0] qq;
            un = magn(n);
            ud = magn(d);
            q  = un / ud;
            if (q >= 64'd128) begin
                q   = {33'd0, cpp_pkg::NORM_MAX};
                sat = 1'b1;
            end else begin
                qq = ({64'd0, un} << 24) / {64'd0, ud};
                q  = qq[63:0];
            end
            return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function logic signed [31:0] clip32(longint v, inout bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1'b1;
                return 32'sh7FFFFFFF;
            end
            if (v < -64'sd2147483648) begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        function t_pixel project(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            t_pixel p;
            bit     sat;
            longint px, py, pz, xc, yc, zc, nx, ny, r2, r4, k1, k2, fac;
            longint focal, su, sv, pu, pv;
            px = x;
            py = y;
            pz = z;
            sat = 1'b0;
            xc = cam_coord(0, px, py, pz);
            yc = cam_coord(1, px, py, pz);
            zc = cam_coord(2, px, py, pz);
            if (zc == 0) begin
                p.u  = '0;
                p.v  = '0;
                p.st = cpp_pkg::ST_ZERO;
                return p;
            end
            nx = norm_div(xc, zc, sat);
            ny = norm_div(yc, zc, sat);
            r2 = mul_shift(nx, nx, 24, sat) + mul_shift(ny, ny, 24, sat);
            r4 = mul_shift(r2, r2, 24, sat);
            k1 = {{32{dcoef[31]}}, dcoef[31:0]};
            k2 = {{32{dcoef[63]}}, dcoef[63:32]};
            fac = 64'sd16777216 + mul_shift(k1, r2, 24, sat) + mul_shift(k2, r4, 24, sat);
            focal = {40'd0, intr[23:0]};
            su = mul_shift(fac, nx, 24, sat);
            sv = mul_shift(fac, ny, 24, sat);
            pu = mul_shift(focal, su, 16, sat) + longint'({44'd0, intr[43:24]}) * 256;
            pv = mul_shift(focal, sv, 16, sat) + longint'({44'd0, intr[63:44]}) * 256;
            p.u  = clip32(pu, sat);
            p.v  = clip32(pv, sat);
            p.st = sat ? cpp_pkg::ST_SAT : cpp_pkg::ST_OK;
            return p;
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            pending_q.push_back(project(x, y, z));
        endfunction

        task check_pixel(logic signed [31:0] u, logic signed [31:0] v, logic [1:0] st);
            t_pixel e;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected pixel u=%h v=%h st=%0d", u, v, st));
            end else begin
                e = pending_q.pop_front();
                checked++;
                if (e.st == cpp_pkg::ST_ZERO) n_zero++;
                if (e.st == cpp_pkg::ST_SAT) n_sat++;
                if (u !== e.u)
                    report($sformatf("pixel_u got %h want %h", u, e.u));
                if (v !== e.v)
                    report($sformatf("pixel_v got %h want %h", v, e.v));
                if (st !== e.st)
                    report($sformatf("status got %0d want %0d", st, e.st));
            end
        endtask

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_pixel_u;
    logic signed [31:0] o_pixel_v;
    logic [1:0]         o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;

    projection_board board = new();
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              n_sent = 0;

    camera_point_projection dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.note_point(i_point_x, i_point_y, i_point_z);
            if (o_valid && !i_stall) board.check_pixel(o_pixel_u, o_pixel_v, o_status);
        end
    end

    task automatic reg_write(cpp_pkg::t_reg_idx idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
    endtask

    // pipeline drained and quiet
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (cpp_pkg::NSTG + 4) @(posedge i_clk);
    endtask

    function automatic logic [62:0] pack_row(int c0, int c1, int c2);
        logic [20:0] a, b, c;
        a = 21'(c0);
        b = 21'(c1);
        c = 21'(c2);
        return {c, b, a};
    endfunction

    // mostly points in front of the camera, some raw noise and some on the z=0 plane
    task automatic random_point();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            send_point($signed($urandom_range(0, 40 << 16)) - (20 << 16),
                       $signed($urandom_range(0, 40 << 16)) - (20 << 16),
                       $urandom_range(1 << 14, 100 << 16));
        else if (sel < 90)
            send_point($urandom, $urandom, $urandom);
        else
            send_point($urandom, $urandom, 32'sd0);
    endtask

    task automatic run_phase(int n, int s_pct, int r_pct, bit hold_once);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            if (hold_once && i == n / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (board.pending() != 0) @(posedge i_clk);
            end
            random_point();
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: identity camera
        send_point(0, 0, 0);
        send_point(1 << 16, 2 << 16, 0);
        send_point(1 << 16, -(1 << 16), 1 << 16);
        send_point(1 << 16, 1 << 16, -(1 << 16));
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 1);
        send_point(32'sh80000000, 32'sh7FFFFFFF, -1);
        send_point(127 << 16, 0, 1 << 16);
        send_point(128 << 16, 0, 1 << 16);
        send_point(-(128 << 16), -(127 << 16), 1 << 16);
        send_point(5, 3, 32'sh7FFFFFFF);
        send_point(32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF);
        drain();

        // typical lens: slight rotation, barrel distortion, 500 px focal length
        reg_write(cpp_pkg::REG_ROT0, pack_row(524000, 15000, -3000));
        reg_write(cpp_pkg::REG_ROT1, pack_row(-15000, 523900, 8000));
        reg_write(cpp_pkg::REG_ROT2, pack_row(3000, -8000, 524200));
        reg_write(cpp_pkg::REG_TX, 32'sd6553);
        reg_write(cpp_pkg::REG_TY, -32'sd13107);
        reg_write(cpp_pkg::REG_TZ, 32'sd32768);
        reg_write(cpp_pkg::REG_DIST, {32'sd838861, -32'sd3355443});
        reg_write(cpp_pkg::REG_INTR, {20'd61440, 20'd81920, 24'd128000});
        send_point(0, 0, 1 << 16);
        send_point(19 << 16, -(19 << 16), 1 << 14);
        send_point(-(20 << 16), 20 << 16, 100 << 16);
        send_point(0, 0, -(32768));
        drain();
        run_phase(400, 16, 64, 1'b1);

        // fully random configuration
        reg_write(cpp_pkg::REG_ROT0, {$urandom, $urandom});
        reg_write(cpp_pkg::REG_ROT1, {$urandom, $urandom});
        reg_write(cpp_pkg::REG_ROT2, {$urandom, $urandom});
        reg_write(cpp_pkg::REG_TX, $urandom);
        reg_write(cpp_pkg::REG_TY, $urandom);
        reg_write(cpp_pkg::REG_TZ, $urandom);
        reg_write(cpp_pkg::REG_DIST, {$urandom, $urandom});
        reg_write(cpp_pkg::REG_INTR, {$urandom, $urandom});
        run_phase(400, 64, 16, 1'b0);

        // extreme registers
        reg_write(cpp_pkg::REG_ROT0, pack_row(-(1 << 20), (1 << 20) - 1, -(1 << 20)));
        reg_write(cpp_pkg::REG_ROT1, {63{1'b1}});
        reg_write(cpp_pkg::REG_ROT2, pack_row((1 << 20) - 1, 0, (1 << 20) - 1));
        reg_write(cpp_pkg::REG_TX, 32'h80000000);
        reg_write(cpp_pkg::REG_TY, 32'h7FFFFFFF);
        reg_write(cpp_pkg::REG_TZ, 32'h7FFFFFFF);
        reg_write(cpp_pkg::REG_DIST, {32'h7FFFFFFF, 32'h80000000});
        reg_write(cpp_pkg::REG_INTR, {64{1'b1}});
        run_phase(200, 0, 0, 1'b0);

        // wide lens back with no idling
        reg_write(cpp_pkg::REG_ROT0, cpp_pkg::ROT0_RST);
        reg_write(cpp_pkg::REG_ROT1, cpp_pkg::ROT1_RST);
        reg_write(cpp_pkg::REG_ROT2, cpp_pkg::ROT2_RST);
        reg_write(cpp_pkg::REG_TX, '0);
        reg_write(cpp_pkg::REG_TY, '0);
        reg_write(cpp_pkg::REG_TZ, '0);
        reg_write(cpp_pkg::REG_DIST, {32'sd1677721, -32'sd6710886});
        reg_write(cpp_pkg::REG_INTR, {20'd122880, 20'd163840, 24'd204800});
        run_phase(200, 0, 0, 1'b0);

        while (board.pending() != 0) begin
            board.report("expected pixel never arrived");
            void'(board.pending_q.pop_front());
        end

        $display("points sent %0d, pixels checked %0d (zero depth %0d, saturated %0d)",
                 n_sent, board.checked, board.n_zero, board.n_sat);
        $display("covered reset, typical, random and extreme camera setups under stalls");
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/cpp_pkg.sv
hw/rtl/camera_point_projection.sv
dv/tb_top.sv
